### hw/rtl/pis_pkg.sv
package pis_pkg;

    localparam int ROWS    = 4;
    localparam int COLUMNS = 1024;
    localparam int ROW_W   = 2;
    localparam int COL_W   = $clog2(COLUMNS);
    localparam int ADDR_W  = ROW_W + COL_W;
    localparam int DEPTH   = ROWS * COLUMNS;

    localparam logic [63:0] MUR_M = 64'hc6a4a7935bd1e995;
    localparam int          MUR_R = 47;

    localparam logic [2:0] CMD_UPDATE = 3'd0;
    localparam logic [2:0] CMD_QUERY  = 3'd1;
    localparam logic [2:0] CMD_TICK   = 3'd2;
    localparam logic [2:0] CMD_WINDOW = 3'd3;
    localparam logic [2:0] CMD_CLEAR  = 3'd4;

    localparam logic [2:0] REG_KEY_BYTES = 3'd0;
    localparam logic [2:0] REG_COLD_BASE = 3'd1;
    localparam logic [2:0] REG_SEED_0    = 3'd2;
    localparam logic [2:0] REG_SEED_3    = 3'd5;

    typedef struct packed {
        logic [63:0] key;
        logic [31:0] count;
        logic        seen;
        logic [7:0]  cold;
    } ent_t;

    localparam int ENT_W = $bits(ent_t);

    function automatic logic [3:0] eff_len(input logic [3:0] kb);
        if (kb == 4'd0)
            return 4'd1;
        else if (kb > 4'd8)
            return 4'd8;
        else
            return kb;
    endfunction

    function automatic logic [63:0] key_mask(input logic [3:0] len);
        if (len >= 4'd8)
            return '1;
        else
            return (64'd1 << {len, 3'b000}) - 64'd1;
    endfunction

    function automatic logic [63:0] len_mul(input logic [3:0] len);
        return MUR_M * {60'd0, len};
    endfunction

endpackage

### hw/rtl/pis_ram.sv
module pis_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

### hw/rtl/pis_hash.sv
module pis_hash
    import pis_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] key,
    input  logic [3:0]  len,
    input  logic [63:0] seed,
    output logic        done,
    output logic [63:0] hash
);

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_K1   = 3'd1;
    localparam logic [2:0] PH_K2   = 3'd2;
    localparam logic [2:0] PH_H1   = 3'd3;
    localparam logic [2:0] PH_H2   = 3'd4;

    logic [2:0]  ph_reg, ph_next;
    logic [1:0]  st_reg, st_next;
    logic [63:0] x_reg, x_next;
    logic [63:0] p_reg, p_next;
    logic [63:0] h_reg, h_next;
    logic        done_reg, done_next;
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    logic [63:0] h0, pmix;

    // 64x64 low product by M over three 32x32 steps, fourth step mixes
    assign mul_a = (st_reg == 2'd1) ? x_reg[63:32] : x_reg[31:0];
    assign mul_b = (st_reg == 2'd2) ? MUR_M[63:32] : MUR_M[31:0];
    assign prod  = mul_a * mul_b;
    assign pmix  = p_reg ^ (p_reg >> MUR_R);
    assign h0    = seed ^ len_mul(len);

    always_comb
    begin
        ph_next   = ph_reg;
        st_next   = st_reg;
        x_next    = x_reg;
        p_next    = p_reg;
        h_next    = h_reg;
        done_next = 1'b0;
        if (start)
        begin
            st_next = 2'd0;
            if (len == 4'd8)
            begin
                h_next  = h0;
                x_next  = key;
                ph_next = PH_K1;
            end
            else
            begin
                h_next  = h0 ^ key;
                x_next  = h0 ^ key;
                ph_next = PH_H1;
            end
        end
        else if (ph_reg != PH_IDLE)
        begin
            st_next = st_reg + 2'd1;
            case (st_reg)
                2'd0: p_next = prod;
                2'd1, 2'd2: p_next = p_reg + {prod[31:0], 32'd0};
                default:
                begin
                    case (ph_reg)
                        PH_K1:
                        begin
                            x_next  = pmix;
                            ph_next = PH_K2;
                        end
                        PH_K2:
                        begin
                            h_next  = h_reg ^ p_reg;
                            x_next  = h_reg ^ p_reg;
                            ph_next = PH_H1;
                        end
                        PH_H1:
                        begin
                            h_next  = pmix;
                            x_next  = pmix;
                            ph_next = PH_H2;
                        end
                        default:
                        begin
                            h_next    = pmix;
                            ph_next   = PH_IDLE;
                            done_next = 1'b1;
                        end
                    endcase
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg   <= PH_IDLE;
            st_reg   <= 2'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            ph_reg   <= ph_next;
            st_reg   <= st_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        p_reg <= p_next;
        h_reg <= h_next;
    end

    assign done = done_reg;
    assign hash = h_reg;

endmodule

### hw/rtl/pis_mod.sv
module pis_mod
    import pis_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] num,
    input  logic [40:0] den,
    output logic        done,
    output logic [31:0] rem
);

    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [31:0] n_reg, n_next;
    logic [31:0] r_reg, r_next;
    logic [32:0] trial;

    // restoring remainder, one numerator bit per cycle
    assign trial = {r_reg, n_reg[31]};

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        n_next    = n_reg;
        r_next    = r_reg;
        if (start)
        begin
            cnt_next  = 6'd0;
            busy_next = 1'b1;
            n_next    = num;
            r_next    = 32'd0;
        end
        else if (busy_reg)
        begin
            n_next = {n_reg[30:0], 1'b0};
            if ({8'd0, trial} >= den)
                r_next = 32'({8'd0, trial} - den);
            else
                r_next = trial[31:0];
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 6'd0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg <= n_next;
        r_reg <= r_next;
    end

    assign done = done_reg;
    assign rem  = r_reg;

endmodule

### hw/rtl/persistent_item_sketch.sv
// Query: per row, four multiplies for an 8-byte key, two for a shorter key;
// up to 4 rows, plus the idle state to accept the beat and the final state to load the result.
// Update: the same, plus the replacement draw (32-step remainder unit) when one is needed.
// Tick, window and clear walk the bucket RAM, one bucket a cycle.
// One item at a time; a result waiting at the output does not block the next accept.
// After reset a clearing pass zeroes all DEPTH (4096) buckets of the RAM, input held off.
module persistent_item_sketch
    import pis_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,   // cmd[2:0], item_key[66:3], rnd[98:67], zero pad
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,   // estimate[31:0], update_total[63:32]
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_wdata
);

    localparam logic [3:0] S_CLR    = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_HSTART = 4'd2;
    localparam logic [3:0] S_HWAIT  = 4'd3;
    localparam logic [3:0] S_RD     = 4'd4;
    localparam logic [3:0] S_MUL    = 4'd5;
    localparam logic [3:0] S_DSTART = 4'd6;
    localparam logic [3:0] S_DWAIT  = 4'd7;
    localparam logic [3:0] S_WALK   = 4'd8;
    localparam logic [3:0] S_FIN    = 4'd9;

    logic [3:0]        state_reg, state_next;
    logic [3:0]        key_bytes_reg;
    logic [7:0]        cold_base_reg;
    logic [63:0]       seed_reg [ROWS];
    logic [2:0]        cmd_reg, cmd_next;
    logic [63:0]       mk_reg, mk_next;
    logic [63:0]       mask_reg, mask_next;
    logic [3:0]        len_reg, len_next;
    logic [31:0]       rnd_reg, rnd_next;
    logic [31:0]       total_reg, total_next;
    logic [31:0]       est_reg, est_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [ADDR_W-1:0] cur_reg, cur_next;
    logic [31:0]       minc_reg, minc_next;
    logic [ADDR_W-1:0] loc_reg, loc_next;
    logic              lseen_reg, lseen_next;
    logic [7:0]        lcold_reg, lcold_next;
    logic [39:0]       w_reg, w_next;
    logic [ADDR_W:0]   wcnt_reg, wcnt_next;
    logic              wv_reg, wv_next;
    logic [ADDR_W-1:0] wpa_reg, wpa_next;
    logic              mv_reg, mv_next;
    logic [63:0]       mdata_reg, mdata_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    ent_t              ram_wdata, rd;
    logic [ENT_W-1:0]  ram_rdata;
    logic              hs_done, md_done;
    logic [63:0]       hs_hash;
    logic [31:0]       md_rem;
    logic              take_min, last_row, in_acc;
    logic [7:0]        v;
    logic [ADDR_W-1:0] hs_addr;

    assign rd       = ent_t'(ram_rdata);
    assign in_acc   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mv_reg;
    assign m_tdata  = mdata_reg;
    assign last_row = (row_reg == ROW_W'(ROWS - 1));
    assign take_min = (row_reg == '0) || (rd.count < minc_reg);
    assign v        = (lcold_reg >= cold_base_reg) ? 8'd1 : cold_base_reg - lcold_reg;
    assign hs_addr  = {row_reg, hs_hash[COL_W-1:0]};

    pis_ram #(.WIDTH(ENT_W), .DEPTH(DEPTH)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pis_hash u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == S_HSTART),
        .key   (mk_reg),
        .len   (len_reg),
        .seed  (seed_reg[row_reg]),
        .done  (hs_done),
        .hash  (hs_hash)
    );

    pis_mod u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == S_DSTART),
        .num   (rnd_reg),
        .den   ({1'b0, w_reg} + 41'd1),
        .done  (md_done),
        .rem   (md_rem)
    );

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        mk_next    = mk_reg;
        mask_next  = mask_reg;
        len_next   = len_reg;
        rnd_next   = rnd_reg;
        total_next = total_reg;
        est_next   = est_reg;
        row_next   = row_reg;
        cur_next   = cur_reg;
        minc_next  = minc_reg;
        loc_next   = loc_reg;
        lseen_next = lseen_reg;
        lcold_next = lcold_reg;
        w_next     = w_reg;
        wcnt_next  = wcnt_reg;
        wv_next    = 1'b0;
        wpa_next   = wpa_reg;
        mv_next    = mv_reg && !m_tready;
        mdata_next = mdata_reg;
        ram_we     = 1'b0;
        ram_waddr  = cur_reg;
        ram_wdata  = rd;
        ram_raddr  = wcnt_reg[ADDR_W-1:0];

        case (state_reg)
            S_CLR:
            begin
                ram_we    = 1'b1;
                ram_waddr = wcnt_reg[ADDR_W-1:0];
                ram_wdata = '0;
                wcnt_next = wcnt_reg + 1'b1;
                if (wcnt_reg == (ADDR_W + 1)'(DEPTH - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_acc)
                begin
                    cmd_next  = s_tdata[2:0];
                    len_next  = eff_len(key_bytes_reg);
                    mask_next = key_mask(eff_len(key_bytes_reg));
                    mk_next   = s_tdata[66:3] & key_mask(eff_len(key_bytes_reg));
                    rnd_next  = s_tdata[98:67];
                    est_next  = 32'd0;
                    row_next  = '0;
                    wcnt_next = '0;
                    case (s_tdata[2:0])
                        CMD_UPDATE:
                        begin
                            if (total_reg != '1)
                                total_next = total_reg + 32'd1;
                            state_next = S_HSTART;
                        end
                        CMD_QUERY:  state_next = S_HSTART;
                        CMD_TICK, CMD_WINDOW: state_next = S_WALK;
                        CMD_CLEAR:
                        begin
                            total_next = 32'd0;
                            state_next = S_WALK;
                        end
                        default:    state_next = S_FIN;
                    endcase
                end
            end
            S_HSTART: state_next = S_HWAIT;
            S_HWAIT:
            begin
                ram_raddr = hs_addr;
                if (hs_done)
                begin
                    cur_next   = hs_addr;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                if (cmd_reg == CMD_UPDATE && rd.count == 32'd0 && !rd.seen)
                begin
                    ram_we          = 1'b1;
                    ram_wdata.key   = mk_reg;
                    ram_wdata.count = 32'd1;
                    ram_wdata.seen  = 1'b1;
                    state_next      = S_FIN;
                end
                else if ((rd.key & mask_reg) == mk_reg)
                begin
                    if (cmd_reg == CMD_QUERY)
                        est_next = rd.count;
                    else if (!rd.seen)
                    begin
                        ram_we = 1'b1;
                        if (rd.count != '1)
                            ram_wdata.count = rd.count + 32'd1;
                        ram_wdata.seen = 1'b1;
                    end
                    state_next = S_FIN;
                end
                else
                begin
                    if (take_min)
                    begin
                        minc_next  = rd.count;
                        loc_next   = cur_reg;
                        lseen_next = rd.seen;
                        lcold_next = rd.cold;
                    end
                    if (!last_row)
                    begin
                        row_next   = row_reg + 1'b1;
                        state_next = S_HSTART;
                    end
                    else if (cmd_reg == CMD_QUERY)
                    begin
                        est_next   = take_min ? rd.count : minc_reg;
                        state_next = S_FIN;
                    end
                    else if (take_min ? rd.seen : lseen_reg)
                        state_next = S_FIN;
                    else
                        state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                w_next     = minc_reg * v;
                state_next = S_DSTART;
            end
            S_DSTART: state_next = S_DWAIT;
            S_DWAIT:
            begin
                if (md_done)
                begin
                    if ({8'd0, md_rem} == w_reg)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = loc_reg;
                        ram_wdata = '{key: mk_reg, count: 32'd1, seen: 1'b1, cold: 8'd0};
                    end
                    state_next = S_FIN;
                end
            end
            S_WALK:
            begin
                // read one bucket a cycle, write it back modified the cycle after
                if (wcnt_reg != (ADDR_W + 1)'(DEPTH))
                begin
                    wv_next   = 1'b1;
                    wpa_next  = wcnt_reg[ADDR_W-1:0];
                    wcnt_next = wcnt_reg + 1'b1;
                end
                if (wv_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = wpa_reg;
                    case (cmd_reg)
                        CMD_TICK:
                        begin
                            if (rd.seen)
                            begin
                                if (rd.cold != 8'd0)
                                    ram_wdata.cold = rd.cold - 8'd1;
                            end
                            else if (rd.cold != 8'hff)
                                ram_wdata.cold = rd.cold + 8'd1;
                        end
                        CMD_WINDOW: ram_wdata.seen = 1'b0;
                        default:
                        begin
                            ram_wdata.key   = 64'd0;
                            ram_wdata.count = 32'd0;
                        end
                    endcase
                end
                else if (wcnt_reg == (ADDR_W + 1)'(DEPTH))
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!mv_reg || m_tready)
                begin
                    mv_next    = 1'b1;
                    mdata_next = {total_reg, est_reg};
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            wcnt_reg      <= '0;
            wv_reg        <= 1'b0;
            mv_reg        <= 1'b0;
            total_reg     <= 32'd0;
            key_bytes_reg <= 4'd8;
            cold_base_reg <= 8'd50;
            for (int i = 0; i < ROWS; i++)
                seed_reg[i] <= 64'd0;
        end
        else
        begin
            state_reg <= state_next;
            wcnt_reg  <= wcnt_next;
            wv_reg    <= wv_next;
            mv_reg    <= mv_next;
            total_reg <= total_next;
            if (cfg_we)
            begin
                if (cfg_index == REG_KEY_BYTES)
                    key_bytes_reg <= cfg_wdata[3:0];
                else if (cfg_index == REG_COLD_BASE)
                    cold_base_reg <= cfg_wdata[7:0];
                else if (cfg_index >= REG_SEED_0 && cfg_index <= REG_SEED_3)
                begin
                    for (int i = 0; i < ROWS; i++)
                        if (cfg_index == REG_SEED_0 + 3'(i))
                            seed_reg[i] <= cfg_wdata;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        mk_reg    <= mk_next;
        mask_reg  <= mask_next;
        len_reg   <= len_next;
        rnd_reg   <= rnd_next;
        est_reg   <= est_next;
        row_reg   <= row_next;
        cur_reg   <= cur_next;
        minc_reg  <= minc_next;
        loc_reg   <= loc_next;
        lseen_reg <= lseen_next;
        lcold_reg <= lcold_next;
        w_reg     <= w_next;
        wpa_reg   <= wpa_next;
        mdata_reg <= mdata_next;
    end

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !ram_we)
        else $error("bucket RAM written while idle");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !s_tready)
        else $error("second beat accepted while busy");

    a_hash_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        hs_done |-> state_reg == S_HWAIT)
        else $error("hash result outside its wait state");

    a_mod_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        md_done |-> state_reg == S_DWAIT)
        else $error("remainder result outside its wait state");

endmodule
